// ===== hdl/orlb_pkg.sv =====
// Shared types and constants of the overwrite ring log buffer.
package orlb_pkg;

    // Number of byte entries in the log store.
    localparam int BUF_DEPTH = 4096;

    // Store position width, derived from the depth.
    localparam int PTR_W = $clog2(BUF_DEPTH);

    // Width that holds a contiguous run (up to BUF_DEPTH) and a block limit.
    localparam int CNT_W = (PTR_W + 1 > 8) ? PTR_W + 1 : 8;

    // Fixed field widths of the ports.
    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 12;
    localparam int LEN_W  = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEN_W-1:0] BLOCK_LIMIT_RESET = 8'd80;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_OPEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT = 2'd1;

    typedef logic [PTR_W-1:0] t_ptr;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_SEND  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Access to the byte store issued with an accepted transaction.
    typedef struct packed {
        logic              we;
        t_ptr              waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        t_ptr              raddr;
    } t_mem_req;

    // Result of one transaction, apart from the stored byte itself.
    typedef struct packed {
        logic              block_valid;
        logic [POS_W-1:0]  block_start;
        logic [LEN_W-1:0]  block_len;
        logic              dropped_oldest;
        logic              rd_sel;
        logic [POS_W-1:0]  fill_level;
    } t_result;

endpackage

// ===== hdl/overwrite_ring_log_buffer.sv =====
// Top level of the overwrite-oldest console log ring buffer.
//
// The block keeps console log bytes in a ring store of BUF_DEPTH bytes that
// holds at most BUF_DEPTH - 1 unsent bytes. Each input transaction carries an
// op: a write appends data_byte and, when the ring is full, drops the oldest
// unsent byte and reports dropped_oldest; a send, while link_open is set and
// data is held, offers one contiguous block from the read position up to the
// write position or the end of the store, at most block_limit bytes long (a
// limit of zero counts as one), and advances the read position if
// link_accepts is set; a read returns the stored byte at read_index (zero for
// an index past the store; a never-written entry reads as an unknown byte).
// Every transaction gives exactly one result transaction, which also reports
// the fill level after the item. One transaction is accepted per cycle while
// o_in_stall is low; its result goes through stage one, which waits for the
// store's registered read data, and then through the output register. The
// pointers live in registers and are updated at acceptance, so a read right
// after a write to the same entry sees the new byte. Configuration writes
// are always taken (ready is tied high) and must only be issued while no
// transaction is in flight. There is no clearing pass after reset; the block
// accepts transactions from the first cycle.
module overwrite_ring_log_buffer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input transaction channel.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [orlb_pkg::OP_W-1:0]         i_op,
    input  logic [orlb_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic                              i_link_accepts,
    input  logic [orlb_pkg::POS_W-1:0]        i_read_index,
    // Result transaction channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_block_valid,
    output logic [orlb_pkg::POS_W-1:0]        o_block_start,
    output logic [orlb_pkg::LEN_W-1:0]        o_block_len,
    output logic                              o_dropped_oldest,
    output logic [orlb_pkg::BYTE_W-1:0]       o_read_data,
    output logic [orlb_pkg::POS_W-1:0]        o_fill_level,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [orlb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [orlb_pkg::BYTE_W-1:0]       i_cfg_data
);
    import orlb_pkg::*;

    logic              in_accept;
    logic              s1_move;
    t_result           ctrl_res;
    t_mem_req          mem_req;
    logic [BYTE_W-1:0] mem_rdata;

    // Stage one waits for the store's read data.
    logic              r_s1_valid;
    t_result           r_s1_res;

    // Output register.
    logic              r_out_valid;
    t_result           r_out_res;
    logic [BYTE_W-1:0] r_out_rdata;

    assign o_cfg_ready = 1'b1;

    // Stage one moves on when the output register is empty or being taken.
    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_accept  = i_in_valid && !o_in_stall;

    orlb_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_op           (i_op),
        .i_data_byte    (i_data_byte),
        .i_link_accepts (i_link_accepts),
        .i_read_index   (i_read_index),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_res          (ctrl_res),
        .o_req          (mem_req)
    );

    orlb_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers; the store's read data is only held for a read item.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_res <= ctrl_res;
        end
        if (s1_move) begin
            r_out_res   <= r_s1_res;
            r_out_rdata <= r_s1_res.rd_sel ? mem_rdata : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_block_valid    = r_out_res.block_valid;
    assign o_block_start    = r_out_res.block_start;
    assign o_block_len      = r_out_res.block_len;
    assign o_dropped_oldest = r_out_res.dropped_oldest;
    assign o_read_data      = r_out_rdata;
    assign o_fill_level     = r_out_res.fill_level;

endmodule

// ===== hdl/orlb_store.sv =====
// Byte store of the log buffer: one write port, one registered read port.
module orlb_store (
    input  logic                          i_clk,
    input  orlb_pkg::t_mem_req            i_req,
    output logic [orlb_pkg::BYTE_W-1:0]   o_rdata
);
    import orlb_pkg::*;

    logic [BYTE_W-1:0] r_mem [BUF_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/orlb_ctrl.sv =====
// Pointer and configuration logic of the log buffer; issues store accesses.
module orlb_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [orlb_pkg::OP_W-1:0]         i_op,
    input  logic [orlb_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic                              i_link_accepts,
    input  logic [orlb_pkg::POS_W-1:0]        i_read_index,
    input  logic                              i_cfg_we,
    input  logic [orlb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [orlb_pkg::BYTE_W-1:0]       i_cfg_data,
    output orlb_pkg::t_result                 o_res,
    output orlb_pkg::t_mem_req                o_req
);
    import orlb_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    // Move a position forward by at most one wrap of the store.
    function automatic t_ptr advance(input t_ptr pos, input logic [LEN_W-1:0] by);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(pos) + SUM_W'(by);
        if (sum >= SUM_W'(BUF_DEPTH)) begin
            sum = sum - SUM_W'(BUF_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    t_ptr              r_read_pos, n_read_pos;
    t_ptr              r_write_pos, n_write_pos;
    logic              r_link_open;
    logic [LEN_W-1:0]  r_block_limit;

    t_ptr              fill_cur;
    t_ptr              fill_after;
    logic              full;
    logic [CNT_W-1:0]  contig;
    logic [LEN_W-1:0]  lim;
    logic [LEN_W-1:0]  blen;
    logic              ridx_ok;
    t_op               op;

    assign op = t_op'(i_op);

    assign fill_cur = (r_write_pos >= r_read_pos) ? (r_write_pos - r_read_pos)
                    : (PTR_W'(BUF_DEPTH) - r_read_pos + r_write_pos);
    assign full = (fill_cur == PTR_W'(BUF_DEPTH - 1));

    // The contiguous run ends at the write position or at the end of the store.
    assign contig = (r_write_pos > r_read_pos) ? CNT_W'(r_write_pos - r_read_pos)
                  : (CNT_W'(BUF_DEPTH) - CNT_W'(r_read_pos));
    assign lim  = (r_block_limit == '0) ? LEN_W'(1) : r_block_limit;
    assign blen = (contig < CNT_W'(lim)) ? contig[LEN_W-1:0] : lim;

    assign ridx_ok = ((POS_W + 1)'(i_read_index) < (POS_W + 1)'(BUF_DEPTH));

    always_comb begin
        n_read_pos  = r_read_pos;
        n_write_pos = r_write_pos;
        fill_after  = fill_cur;
        o_res       = '0;
        o_req       = '0;
        o_req.waddr = r_write_pos;
        o_req.wdata = i_data_byte;
        o_req.raddr = i_read_index[PTR_W-1:0];
        unique case (op)
            OP_WRITE: begin
                o_req.we    = i_accept;
                n_write_pos = advance(r_write_pos, LEN_W'(1));
                if (full) begin
                    n_read_pos           = advance(r_read_pos, LEN_W'(1));
                    o_res.dropped_oldest = 1'b1;
                end else begin
                    fill_after = fill_cur + PTR_W'(1);
                end
            end
            OP_SEND: begin
                if (r_link_open && (fill_cur != '0)) begin
                    o_res.block_valid = 1'b1;
                    o_res.block_start = POS_W'(r_read_pos);
                    o_res.block_len   = blen;
                    if (i_link_accepts) begin
                        n_read_pos = advance(r_read_pos, blen);
                        fill_after = fill_cur - PTR_W'(blen);
                    end
                end
            end
            OP_READ: begin
                o_req.re     = i_accept && ridx_ok;
                o_res.rd_sel = ridx_ok;
            end
            OP_NONE: begin
            end
            default: begin
            end
        endcase
        o_res.fill_level = POS_W'(fill_after);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_pos    <= '0;
            r_write_pos   <= '0;
            r_link_open   <= 1'b0;
            r_block_limit <= BLOCK_LIMIT_RESET;
        end else begin
            if (i_accept) begin
                r_read_pos  <= n_read_pos;
                r_write_pos <= n_write_pos;
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LINK_OPEN) begin
                    r_link_open <= i_cfg_data[0];
                end else if (i_cfg_index == CFG_BLOCK_LIMIT) begin
                    r_block_limit <= i_cfg_data;
                end
            end
        end
    end

endmodule
